>>> rtl/core/byte_fifo_with_watermarks_assert.svh
// assertion macros for the byte fifo checker
`ifndef BYTE_FIFO_WITH_WATERMARKS_ASSERT_SVH
`define BYTE_FIFO_WITH_WATERMARKS_ASSERT_SVH

// property must hold at every clock edge out of reset
`define BFW_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("bfw check failed");

// condition must never be seen at a clock edge out of reset
`define BFW_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("bfw forbidden condition");

`endif

>>> rtl/core/bfw_pkg.sv
// shared types and constants for the byte fifo with watermarks
`timescale 1ns / 1ps
package bfw_pkg;

	localparam int DEPTH = 256;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = (PTR_W > 8) ? PTR_W : 8;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CHECK = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_MIN_THR  = 2'd0,
		REG_MIN_EN   = 2'd1,
		REG_HIGH_THR = 2'd2,
		REG_HIGH_EN  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] min_threshold;
		logic       min_enable;
		logic [7:0] high_threshold;
		logic       high_enable;
		logic       high_clear;
	} cfg_t;

	typedef struct packed {
		logic       accepted;
		logic       pop_ok;
		logic [7:0] fill_count;
		logic [7:0] free_space;
		logic       min_event;
		logic       high_event;
	} res_t;

	function automatic logic [7:0] low_byte(input logic [PTR_W-1:0] v);
		logic [CNT_W-1:0] w;
		w = CNT_W'(v);
		return w[7:0];
	endfunction

endpackage

>>> rtl/core/bfw_ram.sv
// byte storage ring with one write port and one registered read port
`timescale 1ns / 1ps
module bfw_ram (
	input  logic                    clk,
	input  logic                    we,
	input  logic [bfw_pkg::PTR_W-1:0] waddr,
	input  logic [7:0]              wdata,
	input  logic                    re,
	input  logic [bfw_pkg::PTR_W-1:0] raddr,
	output logic [7:0]              rdata
);

	logic [7:0] mem_q [bfw_pkg::DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/bfw_regs.sv
// apb configuration registers for thresholds and enables
`timescale 1ns / 1ps
module bfw_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output bfw_pkg::cfg_t cfg
);

	logic [7:0]        min_thr_q;
	logic              min_en_q;
	logic [7:0]        high_thr_q;
	logic              high_en_q;
	logic              wr_en;
	bfw_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = bfw_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_thr_q  <= '0;
			min_en_q   <= 1'b0;
			high_thr_q <= '0;
			high_en_q  <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				bfw_pkg::REG_MIN_THR:  min_thr_q  <= pwdata[7:0];
				bfw_pkg::REG_MIN_EN:   min_en_q   <= pwdata[0];
				bfw_pkg::REG_HIGH_THR: high_thr_q <= pwdata[7:0];
				bfw_pkg::REG_HIGH_EN:  high_en_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			bfw_pkg::REG_MIN_THR:  prdata = {24'd0, min_thr_q};
			bfw_pkg::REG_MIN_EN:   prdata = {31'd0, min_en_q};
			bfw_pkg::REG_HIGH_THR: prdata = {24'd0, high_thr_q};
			bfw_pkg::REG_HIGH_EN:  prdata = {31'd0, high_en_q};
			default:               prdata = '0;
		endcase
	end

	assign cfg.min_threshold  = min_thr_q;
	assign cfg.min_enable     = min_en_q;
	assign cfg.high_threshold = high_thr_q;
	assign cfg.high_enable    = high_en_q;
	assign cfg.high_clear     = wr_en && (idx == bfw_pkg::REG_HIGH_THR);

endmodule

>>> rtl/core/bfw_ctrl.sv
// ring pointers, watermark flag and per-item result logic
`timescale 1ns / 1ps
module bfw_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  bfw_pkg::cmd_t             cmd,
	input  logic [7:0]                data_in,
	input  bfw_pkg::cfg_t             cfg,
	output logic                      mem_we,
	output logic [bfw_pkg::PTR_W-1:0] mem_waddr,
	output logic [7:0]                mem_wdata,
	output logic                      mem_re,
	output logic [bfw_pkg::PTR_W-1:0] mem_raddr,
	output bfw_pkg::res_t             res
);

	logic [bfw_pkg::PTR_W-1:0] wp_q, rp_q, wp_n, rp_n, level, level_n;
	logic [bfw_pkg::CNT_W-1:0] lvl_c, lvl_n_c;
	logic                      fired_q, fired_n;
	logic                      full, empty, push_ok, pop_ok, is_pop, is_check;
	logic                      min_ev, high_ev;

	assign level    = wp_q - rp_q;
	assign full     = (level == bfw_pkg::PTR_W'(bfw_pkg::DEPTH - 1));
	assign empty    = (wp_q == rp_q);
	assign is_pop   = (cmd == bfw_pkg::CMD_POP);
	assign is_check = (cmd == bfw_pkg::CMD_CHECK);
	assign push_ok  = (cmd == bfw_pkg::CMD_PUSH) && !full;
	assign pop_ok   = is_pop && !empty;

	assign wp_n    = push_ok ? wp_q + 1'b1 : wp_q;
	assign rp_n    = pop_ok ? rp_q + 1'b1 : rp_q;
	assign level_n = wp_n - rp_n;
	assign lvl_c   = bfw_pkg::CNT_W'(level);
	assign lvl_n_c = bfw_pkg::CNT_W'(level_n);

	assign min_ev  = is_check && cfg.min_enable &&
		(lvl_c >= bfw_pkg::CNT_W'(cfg.min_threshold));
	assign high_ev = is_check && cfg.high_enable && !fired_q &&
		(lvl_c >= bfw_pkg::CNT_W'(cfg.high_threshold));

	always_comb begin
		fired_n = fired_q;
		if (high_ev) begin
			fired_n = 1'b1;
		end else if (is_pop && (lvl_n_c < bfw_pkg::CNT_W'(cfg.high_threshold))) begin
			fired_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			fired_q <= 1'b0;
		end else begin
			if (take) begin
				wp_q <= wp_n;
				rp_q <= rp_n;
			end
			if (cfg.high_clear) begin
				fired_q <= 1'b0;
			end else if (take) begin
				fired_q <= fired_n;
			end
		end
	end

	assign mem_we    = take && push_ok;
	assign mem_waddr = wp_q;
	assign mem_wdata = data_in;
	assign mem_re    = take && pop_ok;
	assign mem_raddr = rp_q;

	assign res.accepted   = push_ok || pop_ok;
	assign res.pop_ok     = pop_ok;
	assign res.fill_count = bfw_pkg::low_byte(level_n);
	assign res.free_space =
		bfw_pkg::low_byte(bfw_pkg::PTR_W'(bfw_pkg::DEPTH - 1) - level_n);
	assign res.min_event  = min_ev;
	assign res.high_event = high_ev;

endmodule

>>> rtl/core/byte_fifo_with_watermarks.sv
// top level of the byte fifo with watermark events
// the result of an item is registered and shown in the cycle after the item is taken
// throughput: one item per cycle; s_tready drops only while a result waits unread
// storage lives in a ram with a registered read port, read on the taking edge
// reset: arst_n clears pointers, watermark flag, registers and output valid
// storage contents are not cleared, so no clearing pass follows reset
`timescale 1ns / 1ps
module byte_fifo_with_watermarks (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_in
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] accepted, [8:1] data_out, [16:9] fill_count, [24:17] free_space,
	// [25] min_event, [26] high_event, [31:27] zero
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	bfw_pkg::cfg_t             cfg;
	bfw_pkg::res_t             res, res_s1;
	logic                      valid_s1;
	logic                      take;
	logic                      mem_we, mem_re;
	logic [bfw_pkg::PTR_W-1:0] mem_waddr, mem_raddr;
	logic [7:0]                mem_wdata, mem_rdata, data_out;

	assign s_tready = !valid_s1 || m_tready;
	assign take     = s_tvalid && s_tready;

	bfw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bfw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.cmd       (bfw_pkg::cmd_t'(s_tuser)),
		.data_in   (s_tdata),
		.cfg       (cfg),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res       (res)
	);

	bfw_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= res;
		end
	end

	assign data_out = res_s1.pop_ok ? mem_rdata : 8'd0;
	assign m_tvalid = valid_s1;
	assign m_tdata  = {5'd0, res_s1.high_event, res_s1.min_event, res_s1.free_space,
		res_s1.fill_count, data_out, res_s1.accepted};

endmodule

>>> rtl/core/bfw_checker.sv
// port-level checker for the byte fifo, bound to the top level
`timescale 1ns / 1ps
`include "byte_fifo_with_watermarks_assert.svh"
module bfw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	logic [7:0] sum_chk;

	assign sum_chk = m_tdata[16:9] + m_tdata[24:17];

	`BFW_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	`BFW_ASSERT(a_count_sum, m_tvalid |-> sum_chk == 8'(bfw_pkg::DEPTH - 1))
	`BFW_NEVER(a_data_no_accept, m_tvalid && !m_tdata[0] && (m_tdata[8:1] != 8'd0))
	`BFW_NEVER(a_event_with_accept, m_tvalid && m_tdata[0] && (m_tdata[25] || m_tdata[26]))
	`BFW_NEVER(a_stall_no_result, !s_tready && !(m_tvalid && !m_tready))

endmodule

bind byte_fifo_with_watermarks bfw_checker u_bfw_checker (.*);

>>> dv/byte_fifo_with_watermarks_chk.sv
// checker for the byte fifo: mirrors the ring and the watermark flag and compares each status item
`timescale 1ns / 1ps
module byte_fifo_with_watermarks_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          pending
);

	localparam logic [7:0] FULL_LEVEL = 8'(bfw_pkg::DEPTH - 1);

	// first member sits in the top bits, so this lines up with m_tdata[26:0]
	typedef struct packed {
		logic       high_event;
		logic       min_event;
		logic [7:0] free_space;
		logic [7:0] fill_count;
		logic [7:0] data_out;
		logic       accepted;
	} fifo_status_t;

	logic [7:0]   ring [bfw_pkg::DEPTH];
	logic [7:0]   wr_ptr;
	logic [7:0]   rd_ptr;
	logic         high_fired;
	logic [7:0]   min_thr;
	logic         min_en;
	logic [7:0]   high_thr;
	logic         high_en;
	fifo_status_t status_q [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 40)
			$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	function automatic fifo_status_t predict_status(input logic [1:0] op, input logic [7:0] din);
		fifo_status_t st;
		logic [7:0]   lvl;
		st = '0;
		lvl = wr_ptr - rd_ptr;
		case (op)
			bfw_pkg::CMD_PUSH: begin
				if (lvl != FULL_LEVEL) begin
					ring[wr_ptr] = din;
					wr_ptr = wr_ptr + 8'd1;
					st.accepted = 1'b1;
				end
			end
			bfw_pkg::CMD_POP: begin
				if (wr_ptr != rd_ptr) begin
					st.data_out = ring[rd_ptr];
					rd_ptr = rd_ptr + 8'd1;
					st.accepted = 1'b1;
				end
				lvl = wr_ptr - rd_ptr;
				if (lvl < high_thr)
					high_fired = 1'b0;
			end
			bfw_pkg::CMD_CHECK: begin
				st.min_event = min_en && (lvl >= min_thr);
				if (high_en && lvl >= high_thr && !high_fired) begin
					high_fired = 1'b1;
					st.high_event = 1'b1;
				end
			end
			default: ;
		endcase
		lvl = wr_ptr - rd_ptr;
		st.fill_count = lvl;
		st.free_space = FULL_LEVEL - lvl;
		return st;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fifo_status_t got;
		fifo_status_t want;
		if (!arst_n) begin
			wr_ptr = '0;
			rd_ptr = '0;
			high_fired = 1'b0;
			min_thr = '0;
			min_en = 1'b0;
			high_thr = '0;
			high_en = 1'b0;
			status_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (bfw_pkg::reg_idx_t'(paddr[3:2]))
					bfw_pkg::REG_MIN_THR:  min_thr = pwdata[7:0];
					bfw_pkg::REG_MIN_EN:   min_en = pwdata[0];
					bfw_pkg::REG_HIGH_THR: begin
						high_thr = pwdata[7:0];
						high_fired = 1'b0;
					end
					bfw_pkg::REG_HIGH_EN:  high_en = pwdata[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = fifo_status_t'(m_tdata[26:0]);
				if (status_q.size() == 0) begin
					report_mismatch("status item with none pending", m_tdata, 0);
				end else begin
					want = status_q.pop_front();
					if (got.accepted !== want.accepted)
						report_mismatch("accepted", got.accepted, want.accepted);
					if (got.data_out !== want.data_out)
						report_mismatch("data_out", got.data_out, want.data_out);
					if (got.fill_count !== want.fill_count)
						report_mismatch("fill_count", got.fill_count, want.fill_count);
					if (got.free_space !== want.free_space)
						report_mismatch("free_space", got.free_space, want.free_space);
					if (got.min_event !== want.min_event)
						report_mismatch("min_event", got.min_event, want.min_event);
					if (got.high_event !== want.high_event)
						report_mismatch("high_event", got.high_event, want.high_event);
					if (m_tdata[31:27] !== 5'd0)
						report_mismatch("padding", m_tdata[31:27], 0);
				end
			end
			if (s_tvalid && s_tready)
				status_q.push_back(predict_status(s_tuser, s_tdata));
			pending = status_q.size();
		end
	end

endmodule

>>> dv/byte_fifo_with_watermarks_tb.sv
// top of the byte fifo testbench: clock, reset, item and register stimulus, verdict
`timescale 1ns / 1ps
module byte_fifo_with_watermarks_tb;

	localparam int         WATCHDOG_LIMIT = 5000;
	localparam int         HOLD_CYCLES = 300;
	localparam int         PHASE_ITEMS = 180;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_in
	logic [1:0]  s_tuser;   // [1:0] cmd
	logic        m_tvalid;
	logic        m_tready;
	// [0] accepted, [8:1] data_out, [16:9] fill_count, [24:17] free_space,
	// [25] min_event, [26] high_event, [31:27] zero
	logic [31:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int errors;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int quiet_cycles = 0;

	byte_fifo_with_watermarks uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	byte_fifo_with_watermarks_chk u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				repeat (HOLD_CYCLES) begin
					m_tready <= 1'b0;
					@(negedge clk);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("byte_fifo_with_watermarks_tb: done, errors");
			$finish;
		end
	end

	task automatic set_idle(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
			default: begin send_idle_pct = 34; recv_stall_pct = 34; end
		endcase
	endtask

	task automatic send_item(input logic [1:0] op, input logic [7:0] din);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			s_tuser <= 2'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= din;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(input int push_pct, input int pop_pct);
		int         r;
		logic [1:0] op;
		r = $urandom_range(99);
		if (r < push_pct)
			op = bfw_pkg::CMD_PUSH;
		else if (r < push_pct + pop_pct)
			op = bfw_pkg::CMD_POP;
		else if (r < 97)
			op = bfw_pkg::CMD_CHECK;
		else
			op = CMD_UNUSED;
		send_item(op, 8'($urandom));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input bfw_pkg::reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// junk in the upper bits checks that the registers keep only their width
	task automatic apply_config(input logic [7:0] mthr, input logic men,
		input logic [7:0] hthr, input logic hen);
		write_reg(bfw_pkg::REG_MIN_THR, {24'($urandom), mthr});
		write_reg(bfw_pkg::REG_MIN_EN, {31'($urandom), men});
		write_reg(bfw_pkg::REG_HIGH_THR, {24'($urandom), hthr});
		write_reg(bfw_pkg::REG_HIGH_EN, {31'($urandom), hen});
	endtask

	task automatic run_random(input int n);
		int i;
		int push_pct;
		int pop_pct;
		push_pct = 40;
		pop_pct = 40;
		for (i = 0; i < n; i++) begin
			if (i % 25 == 0) begin
				case ($urandom_range(2))
					0: begin push_pct = 70; pop_pct = 15; end
					1: begin push_pct = 15; pop_pct = 70; end
					default: begin push_pct = 40; pop_pct = 40; end
				endcase
			end
			send_random(push_pct, pop_pct);
		end
	endtask

	// fill past full, check at full, then empty past empty
	task automatic run_fill_drain();
		int i;
		hold_requests++;
		for (i = 0; i < bfw_pkg::DEPTH + 4; i++) begin
			if (i % 16 == 15)
				send_item(bfw_pkg::CMD_CHECK, 8'($urandom));
			send_item(bfw_pkg::CMD_PUSH, 8'($urandom));
		end
		send_item(bfw_pkg::CMD_CHECK, 8'($urandom));
		send_item(bfw_pkg::CMD_CHECK, 8'($urandom));
		send_item(bfw_pkg::CMD_POP, 8'($urandom));
		send_item(bfw_pkg::CMD_CHECK, 8'($urandom));
		send_item(bfw_pkg::CMD_PUSH, 8'($urandom));
		send_item(bfw_pkg::CMD_CHECK, 8'($urandom));
		for (i = 0; i < bfw_pkg::DEPTH + 4; i++) begin
			if (i % 16 == 15)
				send_item(bfw_pkg::CMD_CHECK, 8'($urandom));
			send_item(bfw_pkg::CMD_POP, 8'($urandom));
		end
		send_item(bfw_pkg::CMD_CHECK, 8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening
		set_idle(0);
		apply_config(8'd3, 1'b1, 8'd5, 1'b1);
		send_item(bfw_pkg::CMD_CHECK, 8'h00);
		send_item(bfw_pkg::CMD_POP, 8'h00);
		send_item(bfw_pkg::CMD_PUSH, 8'h00);
		send_item(bfw_pkg::CMD_PUSH, 8'hFF);
		send_item(bfw_pkg::CMD_PUSH, 8'hA5);
		send_item(bfw_pkg::CMD_CHECK, 8'hFF);
		send_item(bfw_pkg::CMD_PUSH, 8'h5A);
		send_item(bfw_pkg::CMD_PUSH, 8'h3C);
		send_item(bfw_pkg::CMD_CHECK, 8'h00);
		send_item(bfw_pkg::CMD_CHECK, 8'h00);
		send_item(bfw_pkg::CMD_POP, 8'hFF);
		send_item(bfw_pkg::CMD_CHECK, 8'h00);
		send_item(bfw_pkg::CMD_PUSH, 8'h81);
		send_item(bfw_pkg::CMD_CHECK, 8'h00);
		send_item(CMD_UNUSED, 8'hFF);
		repeat (5) send_item(bfw_pkg::CMD_POP, 8'h00);
		send_item(bfw_pkg::CMD_POP, 8'hFF);
		send_item(bfw_pkg::CMD_CHECK, 8'h00);
		wait_drained();

		set_idle(0);
		apply_config(8'd0, 1'b1, 8'd0, 1'b1);
		run_random(PHASE_ITEMS);
		wait_drained();

		set_idle(3);
		apply_config(8'd255, 1'b1, 8'd255, 1'b1);
		run_fill_drain();
		wait_drained();

		set_idle(1);
		apply_config(8'($urandom_range(12)), 1'b1, 8'($urandom_range(12)), 1'b1);
		run_random(PHASE_ITEMS);
		wait_drained();

		// enables only: thresholds and the watermark flag carry over
		set_idle(2);
		write_reg(bfw_pkg::REG_MIN_EN, {31'($urandom), 1'b0});
		write_reg(bfw_pkg::REG_HIGH_EN, {31'($urandom), 1'b1});
		run_random(PHASE_ITEMS);
		wait_drained();

		set_idle(3);
		apply_config(8'($urandom), 1'b1, 8'($urandom_range(20)), 1'b0);
		run_random(PHASE_ITEMS);
		wait_drained();

		set_idle(0);
		apply_config(8'd8, 1'b1, 8'd16, 1'b1);
		run_random(PHASE_ITEMS);
		wait_drained();

		repeat (10) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("byte_fifo_with_watermarks_tb: done, clean");
		else
			$display("byte_fifo_with_watermarks_tb: done, errors");
		$finish;
	end

endmodule
